// ----- sv/dpes_pkg.sv -----
`default_nettype none

package dpes_pkg;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 8;
    localparam int DRAW_W   = 7;
    localparam int EDGE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Largest node number that the node fields can carry, plus one.
    localparam int NODE_SPAN = 2 ** NODE_W;
    // A stored edge holds the second endpoint above the first.
    localparam int EDGE_DW   = 2 * NODE_W;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SWAP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_BAD,
        K_LOAD_MARK,
        K_LOAD_KEEP,
        K_SWAP,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [EDGE_W-1:0]   first_edge;
        logic [EDGE_W-1:0]   second_edge;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_fr_bus;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bk_ctl;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_LOAD2,
        S_RD_WAIT,
        S_SW_RD2,
        S_SW_LATCH,
        S_SW_ADJ1,
        S_SW_ADJ2,
        S_SW_DEC,
        S_SW_WR
    } t_state;

endpackage

`default_nettype wire

// ----- sv/dpes_if.sv -----
`default_nettype none

interface dpes_in_if;
    import dpes_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [DRAW_W-1:0]   keep_draw;
    logic [DRAW_W-1:0]   keep_percent;
    logic [EDGE_W-1:0]   first_edge;
    logic [EDGE_W-1:0]   second_edge;

    modport source (
        output valid, action, node_a, node_b, keep_draw, keep_percent,
               first_edge, second_edge,
        input  ready
    );
    modport sink (
        input  valid, action, node_a, node_b, keep_draw, keep_percent,
               first_edge, second_edge,
        output ready
    );
endinterface

interface dpes_out_if;
    import dpes_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   end_first;
    logic [NODE_W-1:0]   end_second;
    logic [COUNT_W-1:0]  edge_count;

    modport source (
        output valid, status, end_first, end_second, edge_count,
        input  ready
    );
    modport sink (
        input  valid, status, end_first, end_second, edge_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/degree_preserving_edge_swap.sv -----
// The back end works on one item at a time, behind a two-entry queue: a swap holds it
// through both edge reads, both adjacency reads and, unless rejected, all adjacency writes.
// Reset is synchronous; afterwards the adjacency memory, min(NODE_COUNT, 256) squared
// bits (65536 at defaults), is cleared one bit a cycle, with no input taken meanwhile.
`default_nettype none

module degree_preserving_edge_swap #(
    parameter int NODE_COUNT    = 256,
    parameter int EDGE_CAPACITY = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpes_in_if.sink   i_in,
    dpes_out_if.source o_out
);
    import dpes_pkg::*;

    t_fr_bus w_fr;
    t_bk_ctl w_ctl;

    dpes_front #(.NODE_COUNT(NODE_COUNT)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (w_ctl),
        .o_fr    (w_fr)
    );

    dpes_back #(
        .NODE_COUNT    (NODE_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fr    (w_fr),
        .o_ctl   (w_ctl),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- sv/dpes_ram.sv -----
`default_nettype none

module dpes_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/dpes_front.sv -----
`default_nettype none

module dpes_front #(
    parameter int NODE_COUNT = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    dpes_in_if.sink               i_in,
    input  wire dpes_pkg::t_bk_ctl i_ctl,
    output dpes_pkg::t_fr_bus     o_fr
);
    import dpes_pkg::*;

    localparam int NCW = $clog2(NODE_COUNT + 1);
    localparam int RW  = (NCW > NODE_W) ? NCW : NODE_W;

    t_cmd       w_cmd;
    logic       w_push;
    logic       w_node_bad;
    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign w_node_bad = (RW'(i_in.node_a) >= RW'(NODE_COUNT))
                     || (RW'(i_in.node_b) >= RW'(NODE_COUNT));

    // Everything that does not depend on the edge list is settled here.
    always_comb begin
        w_cmd.node_a      = i_in.node_a;
        w_cmd.node_b      = i_in.node_b;
        w_cmd.first_edge  = i_in.first_edge;
        w_cmd.second_edge = i_in.second_edge;
        case (i_in.action)
            ACT_LOAD: begin
                if (w_node_bad) begin
                    w_cmd.kind = K_BAD;
                end else if (i_in.keep_draw < i_in.keep_percent) begin
                    w_cmd.kind = K_LOAD_KEEP;
                end else begin
                    w_cmd.kind = K_LOAD_MARK;
                end
            end
            ACT_SWAP: w_cmd.kind = K_SWAP;
            ACT_READ: w_cmd.kind = K_READ;
            default:  w_cmd.kind = K_BAD;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2) && !i_ctl.clearing;
    assign w_push     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (i_ctl.pop) begin
                r_rd <= !r_rd;
            end
            if (w_push && !i_ctl.pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_ctl.pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    assign o_fr.valid = (r_cnt != 2'd0);
    assign o_fr.cmd   = r_q[r_rd];

endmodule

`default_nettype wire

// ----- sv/dpes_back.sv -----
`default_nettype none

module dpes_back #(
    parameter int NODE_COUNT    = 256,
    parameter int EDGE_CAPACITY = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dpes_pkg::t_fr_bus i_fr,
    output dpes_pkg::t_bk_ctl      o_ctl,
    dpes_out_if.source             o_out
);
    import dpes_pkg::*;

    localparam int NODES_USED = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
    localparam int ADJ_DEPTH  = NODES_USED * NODES_USED;
    localparam int AAW        = $clog2(ADJ_DEPTH);
    localparam int EAW        = $clog2(EDGE_CAPACITY);
    localparam int KW         = $clog2(EDGE_CAPACITY + 1);
    localparam int CMPW       = (KW > EDGE_W) ? KW : EDGE_W;
    localparam int OCW        = (KW > COUNT_W) ? KW : COUNT_W;

    function automatic logic [AAW-1:0] adj_addr(input logic [NODE_W-1:0] u,
                                                input logic [NODE_W-1:0] v);
        return AAW'(u) * AAW'(NODES_USED) + AAW'(v);
    endfunction

    function automatic logic [EAW-1:0] edge_addr(input logic [EDGE_W-1:0] e);
        logic [CMPW-1:0] ext;
        ext = CMPW'(e);
        return ext[EAW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [AAW-1:0]      r_clr;
    t_cmd                r_cmd;
    logic [KW-1:0]       r_kept;
    logic [NODE_W-1:0]   r_a, r_b, r_c, r_d;
    logic                r_adj_ad;
    logic [2:0]          r_step;
    t_status             r_load_status;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [NODE_W-1:0]   r_out_r1, r_out_r2;
    logic [COUNT_W-1:0]  r_out_count;

    logic                w_pop;
    logic                w_clr_end;
    logic                w_full;
    logic                w_bad1, w_bad2;
    logic                w_reject;
    logic                w_kept_inc;
    logic [OCW-1:0]      w_kept_ext;
    logic [CMPW-1:0]     w_kept_cmp;

    logic                w_res_load;
    t_status             w_res_status;
    logic [NODE_W-1:0]   w_res_r1, w_res_r2;

    logic                w_adj_we;
    logic [AAW-1:0]      w_adj_waddr, w_adj_raddr;
    logic                w_adj_wdata;
    logic                w_adj_rdata;
    logic                w_edge_we;
    logic [EAW-1:0]      w_edge_waddr, w_edge_raddr;
    logic [EDGE_DW-1:0]  w_edge_wdata, w_edge_rdata;

    logic [NODE_W-1:0]   w_su, w_sv;
    logic                w_sbit;

    dpes_ram #(.WIDTH(1), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (w_adj_we),
        .i_waddr (w_adj_waddr),
        .i_wdata (w_adj_wdata),
        .i_raddr (w_adj_raddr),
        .o_rdata (w_adj_rdata)
    );

    dpes_ram #(.WIDTH(EDGE_DW), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (w_edge_waddr),
        .i_wdata (w_edge_wdata),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rdata)
    );

    assign w_clr_end  = (r_clr == AAW'(ADJ_DEPTH - 1));
    assign w_full     = (r_kept >= KW'(EDGE_CAPACITY));
    assign w_kept_cmp = CMPW'(r_kept);
    assign w_bad1     = (CMPW'(r_cmd.first_edge) >= w_kept_cmp);
    assign w_bad2     = (CMPW'(r_cmd.second_edge) >= w_kept_cmp);
    assign w_kept_ext = OCW'(r_kept);
    assign w_pop      = (r_state == S_IDLE) && i_fr.valid
                     && (!r_out_valid || o_out.ready);

    // A swap must not touch a shared endpoint nor create an existing edge.
    assign w_reject = (r_a == r_c) || (r_a == r_d) || (r_b == r_c) || (r_b == r_d)
                   || r_adj_ad || w_adj_rdata;

    // Clear both old directions first, then set both new directions.
    always_comb begin
        case (r_step)
            3'd0:    begin w_su = r_a; w_sv = r_b; w_sbit = 1'b0; end
            3'd1:    begin w_su = r_b; w_sv = r_a; w_sbit = 1'b0; end
            3'd2:    begin w_su = r_c; w_sv = r_d; w_sbit = 1'b0; end
            3'd3:    begin w_su = r_d; w_sv = r_c; w_sbit = 1'b0; end
            3'd4:    begin w_su = r_a; w_sv = r_d; w_sbit = 1'b1; end
            3'd5:    begin w_su = r_d; w_sv = r_a; w_sbit = 1'b1; end
            3'd6:    begin w_su = r_c; w_sv = r_b; w_sbit = 1'b1; end
            default: begin w_su = r_b; w_sv = r_c; w_sbit = 1'b1; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_cmd.kind)
                    K_LOAD_MARK, K_LOAD_KEEP: n_state = S_LOAD2;
                    K_SWAP:  n_state = (w_bad1 || w_bad2) ? S_IDLE : S_SW_RD2;
                    K_READ:  n_state = w_bad1 ? S_IDLE : S_RD_WAIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_LOAD2:    n_state = S_IDLE;
            S_RD_WAIT:  n_state = S_IDLE;
            S_SW_RD2:   n_state = S_SW_LATCH;
            S_SW_LATCH: n_state = S_SW_ADJ1;
            S_SW_ADJ1:  n_state = S_SW_ADJ2;
            S_SW_ADJ2:  n_state = S_SW_DEC;
            S_SW_DEC:   n_state = w_reject ? S_IDLE : S_SW_WR;
            S_SW_WR: begin
                if (r_step == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_adj_we     = 1'b0;
        w_adj_waddr  = r_clr;
        w_adj_wdata  = 1'b0;
        w_adj_raddr  = '0;
        w_edge_we    = 1'b0;
        w_edge_waddr = edge_addr(r_cmd.first_edge);
        w_edge_wdata = {r_cmd.node_b, r_cmd.node_a};
        w_edge_raddr = edge_addr(r_cmd.first_edge);
        w_kept_inc   = 1'b0;
        w_res_load   = 1'b0;
        w_res_status = STAT_DONE;
        w_res_r1     = '0;
        w_res_r2     = '0;
        case (r_state)
            S_CLEAR: begin
                w_adj_we = 1'b1;
            end
            S_DISPATCH: begin
                case (r_cmd.kind)
                    K_LOAD_MARK, K_LOAD_KEEP: begin
                        w_adj_we    = 1'b1;
                        w_adj_waddr = adj_addr(r_cmd.node_a, r_cmd.node_b);
                        w_adj_wdata = 1'b1;
                        if (r_cmd.kind == K_LOAD_KEEP && !w_full) begin
                            w_edge_we    = 1'b1;
                            w_edge_waddr = r_kept[EAW-1:0];
                            w_kept_inc   = 1'b1;
                        end
                    end
                    K_SWAP: begin
                        if (w_bad1 || w_bad2) begin
                            w_res_load   = 1'b1;
                            w_res_status = STAT_RANGE;
                        end
                    end
                    K_READ: begin
                        if (w_bad1) begin
                            w_res_load   = 1'b1;
                            w_res_status = STAT_RANGE;
                        end
                    end
                    default: begin
                        w_res_load   = 1'b1;
                        w_res_status = STAT_RANGE;
                    end
                endcase
            end
            S_LOAD2: begin
                w_adj_we     = 1'b1;
                w_adj_waddr  = adj_addr(r_cmd.node_b, r_cmd.node_a);
                w_adj_wdata  = 1'b1;
                w_res_load   = 1'b1;
                w_res_status = r_load_status;
            end
            S_RD_WAIT: begin
                w_res_load = 1'b1;
                w_res_r1   = w_edge_rdata[NODE_W-1:0];
                w_res_r2   = w_edge_rdata[EDGE_DW-1:NODE_W];
            end
            S_SW_RD2: begin
                w_edge_raddr = edge_addr(r_cmd.second_edge);
            end
            S_SW_ADJ1: begin
                w_adj_raddr = adj_addr(r_a, r_d);
            end
            S_SW_ADJ2: begin
                w_adj_raddr = adj_addr(r_b, r_c);
            end
            S_SW_DEC: begin
                if (w_reject) begin
                    w_res_load   = 1'b1;
                    w_res_status = STAT_REJECT;
                end
            end
            S_SW_WR: begin
                w_adj_we    = 1'b1;
                w_adj_waddr = adj_addr(w_su, w_sv);
                w_adj_wdata = w_sbit;
                if (r_step == 3'd0) begin
                    w_edge_we    = 1'b1;
                    w_edge_wdata = {r_d, r_a};
                end else if (r_step == 3'd1) begin
                    w_edge_we    = 1'b1;
                    w_edge_waddr = edge_addr(r_cmd.second_edge);
                    w_edge_wdata = {r_b, r_c};
                end
                if (r_step == 3'd7) begin
                    w_res_load = 1'b1;
                end
            end
            default: begin
                w_adj_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_kept      <= '0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AAW'(1);
            end
            if (w_kept_inc) begin
                r_kept <= r_kept + KW'(1);
            end
            if (r_state == S_SW_WR) begin
                r_step <= r_step + 3'd1;
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_fr.cmd;
        end
        if (r_state == S_DISPATCH) begin
            r_load_status <= (r_cmd.kind == K_LOAD_KEEP && w_full) ? STAT_FULL
                                                                    : STAT_DONE;
        end
        if (r_state == S_SW_RD2) begin
            r_a <= w_edge_rdata[NODE_W-1:0];
            r_b <= w_edge_rdata[EDGE_DW-1:NODE_W];
        end
        if (r_state == S_SW_LATCH) begin
            r_c <= w_edge_rdata[NODE_W-1:0];
            r_d <= w_edge_rdata[EDGE_DW-1:NODE_W];
        end
        if (r_state == S_SW_ADJ2) begin
            r_adj_ad <= w_adj_rdata;
        end
        if (w_res_load) begin
            r_out_status <= w_res_status;
            r_out_r1     <= w_res_r1;
            r_out_r2     <= w_res_r2;
            r_out_count  <= w_kept_ext[COUNT_W-1:0];
        end
    end

    assign o_ctl.pop      = w_pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.end_first  = r_out_r1;
    assign o_out.end_second = r_out_r2;
    assign o_out.edge_count = r_out_count;

endmodule

`default_nettype wire
